FILE: hw/rtl/ftv_pkg.sv
// shared types, constants and codes for the fix tag=value parser
// no dependencies; used by every module under hw/rtl
package ftv_pkg;

    localparam int OFFSET_WIDTH = 16;
    localparam int DATA_W       = 8;
    localparam int TAG_W        = 20;
    localparam int CHK_W        = 10;
    localparam int STATUS_W     = 2;
    localparam int TUSER_W      = 1 + STATUS_W;
    localparam int OUT_BITS     = TAG_W + 2 * OFFSET_WIDTH;
    localparam int TDATA_W      = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [TAG_W-1:0]  TAG_MAX      = TAG_W'(999999);
    localparam logic [TAG_W-1:0]  TAG_BEGIN    = TAG_W'(8);
    localparam logic [TAG_W-1:0]  TAG_CHECKSUM = TAG_W'(10);
    localparam logic [CHK_W-1:0]  CHK_SAT      = CHK_W'(1023);
    localparam logic [DATA_W-1:0] EQ_CHAR      = 8'h3D;
    localparam logic [DATA_W-1:0] DIGIT_0      = 8'h30;
    localparam logic [DATA_W-1:0] DIGIT_9      = 8'h39;
    localparam logic [DATA_W-1:0] DELIM_RESET  = 8'h01;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_FORM = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TAGNUM  = 2'd1,
        PH_TAGNAME = 2'd2,
        PH_VALUE   = 2'd3
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL  = 2'd0,
        ST_DISCARD = 2'd1,
        ST_CHK_OK  = 2'd2,
        ST_CHK_BAD = 2'd3
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] delim;
        logic [DATA_W-1:0] second_delim;
        logic              free_form;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              is_delim;
        logic              is_skip;
        logic              is_digit;
        logic              is_eq;
        logic              eob;
    } item_t;

    typedef struct packed {
        logic [TAG_W-1:0]        tag_number;
        logic                    named_tag;
        logic [OFFSET_WIDTH-1:0] field_offset;
        logic [OFFSET_WIDTH-1:0] value_length;
        status_t                 field_status;
        logic                    message_end;
    } result_t;

endpackage

FILE: hw/rtl/ftv_front.sv
// front end: classifies each incoming byte against the delimiter settings
// depends on ftv_pkg
module ftv_front
    import ftv_pkg::*;
(
    input  logic [DATA_W-1:0] data_byte,
    input  logic              end_of_buffer,
    input  cfg_t              cfg,
    output item_t             item
);

    always_comb begin
        item.data_byte = data_byte;
        item.is_delim  = (data_byte == cfg.delim);
        item.is_skip   = (data_byte == cfg.delim) ||
                         ((cfg.second_delim != '0) && (data_byte == cfg.second_delim));
        item.is_digit  = (data_byte >= DIGIT_0) && (data_byte <= DIGIT_9);
        item.is_eq     = (data_byte == EQ_CHAR);
        // buffer end only counts in free-form mode
        item.eob       = end_of_buffer && cfg.free_form;
    end

endmodule

FILE: hw/rtl/ftv_fifo.sv
// short queue of classified bytes between front end and parse engine
// depends on ftv_pkg
module ftv_fifo
    import ftv_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t pop_item
);

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;

    assign full      = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rptr_reg];

    always_comb begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/ftv_engine.sv
// back end: field parser state, checksum tracking and the result register
// depends on ftv_pkg; fed from ftv_fifo
module ftv_engine
    import ftv_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    free_form,
    input  logic    in_valid,
    input  item_t   in_item,
    output logic    in_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    phase_t                  phase_reg, phase_next;
    logic [TAG_W-1:0]        acc_reg, acc_next;
    logic                    named_reg, named_next;
    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;
    logic [OFFSET_WIDTH-1:0] start_reg, start_next;
    logic [OFFSET_WIDTH-1:0] vcnt_reg, vcnt_next;
    logic [DATA_W-1:0]       fsum_reg, fsum_next;
    logic [DATA_W-1:0]       rcs_reg, rcs_next;
    logic [CHK_W-1:0]        chk_reg, chk_next;
    logic [1:0]              fim_reg, fim_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg, out_next;

    logic                    fin;
    logic                    fin_eob;
    logic                    mend;
    status_t                 status;
    logic [3:0]              dval;
    logic [TAG_W+3:0]        tag_mul;
    logic [CHK_W+3:0]        chk_mul;

    assign in_pop     = in_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    assign dval    = 4'(in_item.data_byte - DIGIT_0);
    assign tag_mul = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + (TAG_W+4)'(dval);
    assign chk_mul = ({4'b0, chk_reg} << 3) + ({4'b0, chk_reg} << 1) + (CHK_W+4)'(dval);

    // parse phase next state
    always_comb begin
        phase_next = phase_reg;
        if (in_pop) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (!in_item.is_skip) begin
                        if (in_item.is_eq) begin
                            phase_next = PH_VALUE;
                        end else if (in_item.is_digit) begin
                            phase_next = PH_TAGNUM;
                        end else begin
                            phase_next = PH_TAGNAME;
                        end
                    end
                end
                PH_TAGNUM: begin
                    if (!in_item.is_digit) begin
                        phase_next = in_item.is_eq ? PH_VALUE : PH_TAGNAME;
                    end
                end
                PH_TAGNAME: begin
                    if (in_item.is_eq) begin
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    phase_next = PH_VALUE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
            if (fin) begin
                phase_next = PH_IDLE;
            end
        end
    end

    // field datapath and result
    always_comb begin
        acc_next       = acc_reg;
        named_next     = named_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        vcnt_next      = vcnt_reg;
        fsum_next      = fsum_reg;
        rcs_next       = rcs_reg;
        chk_next       = chk_reg;
        fim_next       = fim_reg;
        fin            = 1'b0;
        fin_eob        = 1'b0;
        mend           = 1'b0;
        status         = ST_NORMAL;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (in_pop) begin
            if (phase_reg == PH_IDLE) begin
                if (in_item.is_skip) begin
                    if (pos_reg != '0) begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (in_item.eob) begin
                        pos_next = '0;
                        rcs_next = '0;
                        fim_next = '0;
                    end
                end else begin
                    start_next = pos_reg;
                    fsum_next  = in_item.data_byte;
                    vcnt_next  = '0;
                    chk_next   = '0;
                    named_next = !in_item.is_digit;
                    acc_next   = in_item.is_digit ? TAG_W'(dval) : '0;
                    pos_next   = pos_reg + 1'b1;
                    fin        = in_item.eob;
                    fin_eob    = in_item.eob;
                end
            end else if (in_item.is_delim) begin
                pos_next = pos_reg + 1'b1;
                fin      = 1'b1;
                fin_eob  = in_item.eob;
            end else begin
                fsum_next = fsum_reg + in_item.data_byte;
                pos_next  = pos_reg + 1'b1;
                if (phase_reg == PH_TAGNUM) begin
                    if (in_item.is_digit) begin
                        acc_next = (tag_mul > {4'b0, TAG_MAX}) ? TAG_MAX : tag_mul[TAG_W-1:0];
                    end
                end else if (phase_reg == PH_VALUE) begin
                    if (vcnt_reg != '1) begin
                        vcnt_next = vcnt_reg + 1'b1;
                    end
                    if (in_item.is_digit) begin
                        chk_next = ((chk_reg >= CHK_SAT) || (chk_mul > {4'b0, CHK_SAT})) ?
                                   CHK_SAT : chk_mul[CHK_W-1:0];
                    end else begin
                        chk_next = CHK_SAT;
                    end
                end
                fin     = in_item.eob;
                fin_eob = in_item.eob;
            end

            if (fin) begin
                if (!free_form && (fim_reg == '0) && (named_next || (acc_next != TAG_BEGIN))) begin
                    status   = ST_DISCARD;
                    pos_next = '0;
                    rcs_next = '0;
                    fim_next = '0;
                end else if (!named_next && (acc_next == TAG_CHECKSUM)) begin
                    status = (chk_next == {2'b0, rcs_reg}) ? ST_CHK_OK : ST_CHK_BAD;
                    if (!free_form) begin
                        mend     = 1'b1;
                        pos_next = '0;
                        rcs_next = '0;
                        fim_next = '0;
                    end
                end else begin
                    rcs_next = rcs_reg + fsum_next + 1'b1;
                    if (fim_reg != 2'd3) begin
                        fim_next = fim_reg + 1'b1;
                    end
                end
                if (fin_eob && !mend) begin
                    mend     = 1'b1;
                    pos_next = '0;
                    rcs_next = '0;
                    fim_next = '0;
                end
                out_valid_next          = 1'b1;
                out_next.tag_number     = named_next ? '0 : acc_next;
                out_next.named_tag      = named_next;
                out_next.field_offset   = start_next;
                out_next.value_length   = vcnt_next;
                out_next.field_status   = status;
                out_next.message_end    = mend;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            named_reg     <= 1'b0;
            pos_reg       <= '0;
            start_reg     <= '0;
            vcnt_reg      <= '0;
            fsum_reg      <= '0;
            rcs_reg       <= '0;
            chk_reg       <= '0;
            fim_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            named_reg     <= named_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            vcnt_reg      <= vcnt_next;
            fsum_reg      <= fsum_next;
            rcs_reg       <= rcs_next;
            chk_reg       <= chk_next;
            fim_reg       <= fim_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    // a stalled result blocks the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |-> !in_pop)
        else $error("item taken while result stalled");

    // checksum verdicts only for numeric tag 10
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.field_status == ST_CHK_OK ||
                           out_reg.field_status == ST_CHK_BAD))
        |-> (!out_reg.named_tag && out_reg.tag_number == TAG_CHECKSUM))
        else $error("checksum status on wrong tag");

    // named tags report number zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.named_tag) |-> (out_reg.tag_number == '0))
        else $error("named tag with nonzero number");

    // no checksum accumulates before a field was counted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fim_reg == '0) |-> (rcs_reg == '0))
        else $error("running checksum without counted fields");

endmodule

FILE: hw/rtl/fix_tag_value_parser.sv
// fix tag=value parser: one message byte per transfer, one result per field
// path: a closing byte's result reaches m_ through the queue write, then the engine's
// result register
// throughput: one byte per cycle while results are not stalled, set by the parse engine; a 4-entry
// queue decouples byte intake from result backpressure
// reset: synchronous active-low aresetn clears parser state, queue and registers
// (delimiter 0x01, no second delimiter, session mode); no clearing pass
module fix_tag_value_parser
    import ftv_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [DATA_W-1:0]       s_tdata,    // data_byte
    input  logic                    s_tlast,    // end_of_buffer
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TDATA_W-1:0]      m_tdata,    // tag_number, field_offset, value_length, zero pad
    output logic [TUSER_W-1:0]      m_tuser,    // named_tag, field_status
    output logic                    m_tlast,    // message_end
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DATA_W-1:0]       cfg_wdata
);

    cfg_t    cfg_reg, cfg_next;
    item_t   front_item;
    item_t   queue_item;
    logic    queue_full;
    logic    queue_valid;
    logic    queue_pop;
    result_t result;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DELIM:     cfg_next.delim        = cfg_wdata;
                CFG_SECOND:    cfg_next.second_delim = cfg_wdata;
                CFG_FREE_FORM: cfg_next.free_form    = cfg_wdata[0];
                default:       cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delim        <= DELIM_RESET;
            cfg_reg.second_delim <= '0;
            cfg_reg.free_form    <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !queue_full;

    ftv_front u_front (
        .data_byte     (s_tdata),
        .end_of_buffer (s_tlast),
        .cfg           (cfg_reg),
        .item          (front_item)
    );

    ftv_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && !queue_full),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_item  (queue_item)
    );

    ftv_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .free_form  (cfg_reg.free_form),
        .in_valid   (queue_valid),
        .in_item    (queue_item),
        .in_pop     (queue_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = TDATA_W'({result.value_length, result.field_offset, result.tag_number});
    assign m_tuser = {result.field_status, result.named_tag};
    assign m_tlast = result.message_end;

endmodule

FILE: dv/tb_fix_tag_value_parser.sv
// self-checking testbench for fix_tag_value_parser: byte stream in, one checked result per field
// depends on ftv_pkg and fix_tag_value_parser; needs nothing else
// a queue-fed driver and a clocked monitor compare every result with a local parser prediction
`timescale 1ns / 100ps

module tb_fix_tag_value_parser;
    import ftv_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              eob;
    } stream_byte_t;

    typedef enum int {NO_STALL, SENDER_IDLE, RECEIVER_STALL, BOTH_STALL} traffic_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [TUSER_W-1:0]   m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_wdata;

    // byte source and expected field reports
    stream_byte_t tx_bytes[$];
    result_t      expected_fields[$];
    stream_byte_t next_byte;
    result_t      head_field;
    traffic_t     stall_mode = NO_STALL;
    bit           byte_taken = 1'b0;
    bit           src_gap;
    bit           sink_stall;

    // parser prediction state
    cfg_t                    cur_cfg;
    phase_t                  ph;
    logic [TAG_W-1:0]        tag_acc;
    logic                    tag_named;
    logic [OFFSET_WIDTH-1:0] pos;
    logic [OFFSET_WIDTH-1:0] fstart;
    logic [OFFSET_WIDTH-1:0] vcount;
    logic [7:0]              fsum;
    logic [7:0]              run_sum;
    logic [CHK_W-1:0]        chk_val;
    logic [1:0]              nfields;

    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned bytes_queued = 0;
    int unsigned fields_checked = 0;
    int unsigned msg_ends = 0;
    int unsigned chk_matches = 0;
    int unsigned discards = 0;
    int unsigned settings_run = 1;
    int unsigned ff_sum = 0;

    fix_tag_value_parser i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // data_byte
        .s_tlast   (s_tlast),   // end_of_buffer
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // tag_number, field_offset, value_length, zero pad
        .m_tuser   (m_tuser),   // named_tag, field_status
        .m_tlast   (m_tlast),   // message_end
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    function automatic void restart_msg();
        pos     = '0;
        run_sum = '0;
        nfields = '0;
    endfunction

    function automatic void close_field(logic eob_end);
        result_t r;
        r.tag_number   = tag_named ? '0 : tag_acc;
        r.named_tag    = tag_named;
        r.field_offset = fstart;
        r.value_length = vcount;
        r.field_status = ST_NORMAL;
        r.message_end  = 1'b0;
        if (!cur_cfg.free_form && nfields == 2'd0 && (tag_named || tag_acc != TAG_BEGIN)) begin
            r.field_status = ST_DISCARD;
            restart_msg();
        end else if (!tag_named && tag_acc == TAG_CHECKSUM) begin
            if (chk_val == {2'b00, run_sum}) begin
                r.field_status = ST_CHK_OK;
            end else begin
                r.field_status = ST_CHK_BAD;
            end
            if (!cur_cfg.free_form) begin
                r.message_end = 1'b1;
                restart_msg();
            end
        end else begin
            run_sum = run_sum + fsum + 8'd1;
            if (nfields != 2'd3) nfields = nfields + 2'd1;
        end
        if (eob_end && !r.message_end) begin
            r.message_end = 1'b1;
            restart_msg();
        end
        ph = PH_IDLE;
        expected_fields.push_back(r);
    endfunction

    function automatic void consume_byte(logic [7:0] b, logic eob_in);
        logic        eob;
        logic        digit;
        int unsigned acc_next;
        int unsigned chk_next;
        eob   = eob_in && cur_cfg.free_form;
        digit = (b >= DIGIT_0) && (b <= DIGIT_9);
        if (ph == PH_IDLE) begin
            if (b == cur_cfg.delim || (cur_cfg.second_delim != 8'h00 && b == cur_cfg.second_delim)) begin
                if (pos != '0) pos = pos + 1'b1;
                if (eob) restart_msg();
                return;
            end
            fstart    = pos;
            fsum      = b;
            vcount    = '0;
            chk_val   = '0;
            tag_named = !digit;
            tag_acc   = digit ? TAG_W'(b - DIGIT_0) : '0;
            if (b == EQ_CHAR) begin
                ph = PH_VALUE;
            end else if (digit) begin
                ph = PH_TAGNUM;
            end else begin
                ph = PH_TAGNAME;
            end
            pos = pos + 1'b1;
            if (eob) close_field(1'b1);
            return;
        end
        if (b == cur_cfg.delim) begin
            pos = pos + 1'b1;
            close_field(eob);
            return;
        end
        fsum = fsum + b;
        pos  = pos + 1'b1;
        case (ph)
            PH_TAGNUM: begin
                if (digit) begin
                    acc_next = int'(tag_acc) * 10 + int'(b - DIGIT_0);
                    tag_acc  = (acc_next > TAG_MAX) ? TAG_MAX : TAG_W'(acc_next);
                end else if (b == EQ_CHAR) begin
                    ph = PH_VALUE;
                end else begin
                    ph = PH_TAGNAME;
                end
            end
            PH_TAGNAME: begin
                if (b == EQ_CHAR) ph = PH_VALUE;
            end
            default: begin
                if (vcount != '1) vcount = vcount + 1'b1;
                if (digit) begin
                    chk_next = int'(chk_val) * 10 + int'(b - DIGIT_0);
                    if (chk_val >= CHK_SAT || chk_next > CHK_SAT) begin
                        chk_val = CHK_SAT;
                    end else begin
                        chk_val = CHK_W'(chk_next);
                    end
                end else begin
                    chk_val = CHK_SAT;
                end
            end
        endcase
        if (eob) close_field(1'b1);
    endfunction

    task automatic report_error(string msg);
        mismatches++;
        // keep the log short when the design is badly off
        if (mismatches <= 40) $display("error at cycle %0d: %s", cycles, msg);
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) report_error($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // stimulus helpers
    function automatic void push_byte(logic [7:0] b, logic eob);
        stream_byte_t it;
        // end of buffer is meaningless in session mode, so set it there at random
        if (!cur_cfg.free_form && $urandom_range(99) < 3) eob = 1'b1;
        it.data_byte = b;
        it.eob       = eob;
        tx_bytes.push_back(it);
        bytes_queued++;
    endfunction

    function automatic string content_text(int n);
        string       s;
        logic [7:0]  c;
        s = "";
        repeat (n) begin
            do begin
                c = ($urandom_range(9) < 3) ? 8'($urandom_range(1, 254))
                                            : 8'($urandom_range(32, 126));
            end while (c == cur_cfg.delim ||
                       (cur_cfg.second_delim != 8'h00 && c == cur_cfg.second_delim));
            s = $sformatf("%s%c", s, c);
        end
        return s;
    endfunction

    function automatic string tag_text(bit clean);
        int unsigned t;
        t = $urandom_range(1, 999);
        if (t == 10) t = 11;
        if (clean) return $sformatf("%0d", t);
        case ($urandom_range(4))
            0: return $sformatf("%0d", $urandom_range(1000000, 99999999));
            1: return $sformatf("%c%0d", 8'h41 + $urandom_range(25), $urandom_range(99));
            2: return $sformatf("%0dx", t);
            3: return "";
            default: return $sformatf("%0d", t);
        endcase
    endfunction

    task automatic emit_field(string txt, bit eob_last, inout int unsigned sum);
        for (int i = 0; i < txt.len(); i++) begin
            push_byte(txt[i], eob_last && i == txt.len() - 1);
            sum += txt[i];
        end
        sum += 1;
        if (!eob_last) push_byte(cur_cfg.delim, 1'b0);
    endtask

    task automatic session_msg(bit clean);
        int unsigned sum;
        int unsigned unused;
        int          n;
        string       chk;
        sum    = 0;
        unused = 0;
        if (!clean && $urandom_range(3) == 0) begin
            emit_field({tag_text(1'b0), "=x"}, 1'b0, sum);
            sum = 0;
        end
        emit_field($sformatf("8=FIX.4.%0d", $urandom_range(4)), 1'b0, sum);
        n = $urandom_range(1, 5);
        repeat (n) begin
            if ($urandom_range(4) == 0) begin
                if (cur_cfg.second_delim != 8'h00 && $urandom_range(1) == 1) begin
                    push_byte(cur_cfg.second_delim, 1'b0);
                end else begin
                    push_byte(cur_cfg.delim, 1'b0);
                end
            end
            if (clean || $urandom_range(5) != 0) begin
                emit_field({tag_text(clean), "=", content_text($urandom_range(8))}, 1'b0, sum);
            end else begin
                emit_field(tag_text(1'b0), 1'b0, sum);
            end
        end
        chk = $sformatf("%03d", sum % 256);
        if (!clean) begin
            case ($urandom_range(4))
                1: chk = $sformatf("%03d", (sum + $urandom_range(1, 255)) % 256);
                2: chk = "";
                3: chk = "99999";
                4: chk = "1z";
                default: ;
            endcase
        end
        emit_field({"10=", chk}, 1'b0, unused);
    endtask

    task automatic free_form_field();
        string       txt;
        bit          is_ten;
        int unsigned keep;
        int          r;
        keep   = ff_sum;
        is_ten = ($urandom_range(99) < 20);
        if (is_ten) begin
            txt = {"10=", ($urandom_range(1) == 1) ? $sformatf("%0d", ff_sum % 256)
                                                    : content_text($urandom_range(3))};
        end else begin
            txt = {tag_text(1'($urandom_range(1))), "=", content_text($urandom_range(8))};
        end
        r = $urandom_range(99);
        emit_field(txt, r >= 70 && r < 85, ff_sum);
        if (is_ten) ff_sum = keep;
        if (r >= 85) tx_bytes[tx_bytes.size() - 1].eob = 1'b1;
        if (r >= 70) ff_sum = 0;
    endtask

    task automatic line_noise();
        logic [7:0] b;
        int         r;
        repeat ($urandom_range(1, 16)) begin
            r = $urandom_range(9);
            if (r < 2) begin
                b = cur_cfg.delim;
            end else if (r < 3) begin
                b = EQ_CHAR;
            end else if (r < 6) begin
                b = DIGIT_0 + 8'($urandom_range(9));
            end else begin
                b = 8'($urandom_range(255));
            end
            push_byte(b, $urandom_range(9) == 0);
        end
        if ($urandom_range(1) == 1) push_byte(cur_cfg.delim, 1'b0);
    endtask

    task automatic random_traffic(int unsigned budget);
        int unsigned start;
        int          r;
        start  = bytes_queued;
        ff_sum = 0;
        while (bytes_queued - start < budget) begin
            r = $urandom_range(99);
            if (cur_cfg.free_form) begin
                if (r < 85) free_form_field();
                else line_noise();
            end else if (r < 70) begin
                session_msg(1'b1);
            end else if (r < 88) begin
                session_msg(1'b0);
            end else begin
                line_noise();
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (tx_bytes.size() != 0 || s_tvalid || expected_fields.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_setting(logic [7:0] d, logic [7:0] d2, logic ff, traffic_t mode);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DELIM;
        cfg_wdata <= d;
        @(negedge aclk);
        cfg_index <= CFG_SECOND;
        cfg_wdata <= d2;
        @(negedge aclk);
        cfg_index <= CFG_FREE_FORM;
        cfg_wdata <= {7'd0, ff};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_cfg.delim        = d;
        cur_cfg.second_delim = d2;
        cur_cfg.free_form    = ff;
        stall_mode           = mode;
        settings_run++;
    endtask

    // driver
    always @(negedge aclk) begin
        src_gap    = (stall_mode == SENDER_IDLE && $urandom_range(99) < 85) ||
                     (stall_mode == BOTH_STALL && $urandom_range(99) < 8);
        sink_stall = (stall_mode == RECEIVER_STALL && $urandom_range(99) < 85) ||
                     (stall_mode == BOTH_STALL && $urandom_range(99) < 8);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            if (tx_bytes.size() != 0 && !src_gap) begin
                next_byte = tx_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_byte.data_byte;
                s_tlast  <= next_byte.eob;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= !sink_stall;
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            byte_taken = 1'b0;
        end else if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            cycles++;
            byte_taken = s_tvalid && s_tready;
            if (byte_taken) consume_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_fields.size() == 0) begin
                    report_error("result transfer with no field pending");
                end else begin
                    head_field = expected_fields.pop_front();
                    check_field("tag_number", head_field.tag_number, m_tdata[TAG_W-1:0]);
                    check_field("field_offset", head_field.field_offset,
                                m_tdata[TAG_W +: OFFSET_WIDTH]);
                    check_field("value_length", head_field.value_length,
                                m_tdata[TAG_W + OFFSET_WIDTH +: OFFSET_WIDTH]);
                    check_field("named_tag", head_field.named_tag, m_tuser[0]);
                    check_field("field_status", head_field.field_status,
                                m_tuser[1 +: STATUS_W]);
                    check_field("message_end", head_field.message_end, m_tlast);
                    fields_checked++;
                    if (head_field.message_end) msg_ends++;
                    if (head_field.field_status == ST_CHK_OK) chk_matches++;
                    if (head_field.field_status == ST_DISCARD) discards++;
                end
            end
        end
    end

    initial begin
        int unsigned scratch;
        scratch   = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_DELIM;
        cfg_wdata = '0;
        cur_cfg   = '{delim: DELIM_RESET, second_delim: 8'h00, free_form: 1'b0};
        ph        = PH_IDLE;
        tag_acc   = '0;
        tag_named = 1'b0;
        pos       = '0;
        fstart    = '0;
        vcount    = '0;
        fsum      = '0;
        run_sum   = '0;
        chk_val   = '0;
        nfields   = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // session mode at reset values: leading delimiters, named opener discarded,
        // empty value, no equals sign, digits then letters, empty checksum
        push_byte(DELIM_RESET, 1'b0);
        push_byte(DELIM_RESET, 1'b0);
        emit_field("A=", 1'b0, scratch);
        emit_field("8=", 1'b0, scratch);
        push_byte("9", 1'b1);
        push_byte(DELIM_RESET, 1'b0);
        emit_field("1a=x", 1'b0, scratch);
        emit_field("10=", 1'b0, scratch);
        wait_idle();

        apply_setting(8'h01, 8'h0A, 1'b0, SENDER_IDLE);
        random_traffic(180);
        wait_idle();

        apply_setting(8'h7C, 8'hFF, 1'b0, RECEIVER_STALL);
        random_traffic(180);
        wait_idle();

        // free form: buffer end with nothing open, checksum tag closed by buffer end
        apply_setting(8'h00, 8'h00, 1'b1, BOTH_STALL);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        emit_field("10=9z", 1'b1, scratch);
        random_traffic(180);
        wait_idle();

        // free form with an all-ones delimiter: one long value, then a field closed by buffer end
        apply_setting(8'hFF, 8'h01, 1'b1, NO_STALL);
        push_byte("1", 1'b0);
        push_byte(EQ_CHAR, 1'b0);
        repeat (40) push_byte("A", 1'b0);
        push_byte(8'hFF, 1'b0);
        emit_field("2=x", 1'b1, scratch);
        random_traffic(180);
        wait_idle();

        apply_setting(8'h01, 8'h00, 1'b0, RECEIVER_STALL);
        random_traffic(180);
        wait_idle();

        repeat (8) @(posedge aclk);
        if (expected_fields.size() != 0) begin
            report_error($sformatf("%0d field reports never arrived", expected_fields.size()));
        end
        $display("run covered %0d bytes under %0d register settings, %0d fields checked",
                 bytes_queued, settings_run, fields_checked);
        $display("%0d message ends, %0d checksum matches, %0d discarded openers, %0d errors",
                 msg_ends, chk_matches, discards, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
